@@ rtl/core/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// mct_pkg
// Types and constants shared by the multiset count table unit.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int ELEM_W      = 32;
    localparam int CNT_W       = 16;
    localparam int OUT_CNT_W   = 16;
    localparam int TOTAL_W     = 22;
    localparam int NBEST_W     = IDX_W + 1;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_COUNT  = 2'd2;
    localparam logic [1:0] CMD_MAXF   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] elem_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        count;
        logic [TOTAL_W-1:0] total_elements;
        logic               is_empty;
    } t_out_word;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

    // Result of one sweep over the table
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   found_idx;
        logic [CNT_W-1:0]   found_cnt;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [CNT_W-1:0]   best;
        logic [NBEST_W-1:0] nbest;
    } t_scan;

endpackage

@@ rtl/core/mct_store.sv @@
// ----------------------------------------------------------------------------
// mct_store
// Entry memory: value and count per entry, one write and one registered read
// port, with an occupancy flag per entry that reset clears.
// ----------------------------------------------------------------------------
module mct_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [mct_pkg::IDX_W-1:0] i_rd_addr,
    output mct_pkg::t_entry          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [mct_pkg::IDX_W-1:0] i_wr_addr,
    input  mct_pkg::t_entry          i_wr_data
);
    import mct_pkg::*;

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_used;
    t_entry             r_rd_word;
    logic               r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_used[i_wr_addr] <= (i_wr_data.cnt != '0);
            end
            if (i_rd_en) begin
                r_rd_used <= r_used[i_rd_addr];
            end
        end
    end

    // A free entry reads as count zero
    always_comb begin
        o_rd_data.value = r_rd_word.value;
        o_rd_data.cnt   = r_rd_used ? r_rd_word.cnt : '0;
    end

endmodule

@@ rtl/core/mct_scan.sv @@
// ----------------------------------------------------------------------------
// mct_scan
// Sweep accumulator: finds the matching entry, the lowest free entry, the
// highest count and how many entries share it, one entry per cycle while i_en is high.
// ----------------------------------------------------------------------------
module mct_scan (
    input  logic                      i_clk,
    input  logic                      i_clr,
    input  logic                      i_en,
    input  logic [mct_pkg::IDX_W-1:0]  i_idx,
    input  mct_pkg::t_entry           i_entry,
    input  logic [mct_pkg::ELEM_W-1:0] i_key,
    output mct_pkg::t_scan            o_scan
);
    import mct_pkg::*;

    t_scan r_scan;
    t_scan n_scan;

    always_comb begin
        n_scan = r_scan;
        if (i_clr) begin
            n_scan = '0;
        end else if (i_en) begin
            if (i_entry.cnt != '0 && i_entry.value == i_key && !r_scan.found) begin
                n_scan.found     = 1'b1;
                n_scan.found_idx = i_idx;
                n_scan.found_cnt = i_entry.cnt;
            end
            if (i_entry.cnt == '0 && !r_scan.free_found) begin
                n_scan.free_found = 1'b1;
                n_scan.free_idx   = i_idx;
            end
            if (i_entry.cnt > r_scan.best) begin
                n_scan.best  = i_entry.cnt;
                n_scan.nbest = NBEST_W'(1);
            end else if (i_entry.cnt == r_scan.best && i_entry.cnt != '0) begin
                n_scan.nbest = r_scan.nbest + NBEST_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

@@ rtl/core/multiset_count_table_unit.sv @@
// ----------------------------------------------------------------------------
// multiset_count_table_unit
// Bounded multiset of 64 distinct values with 16-bit occurrence counts.
// ----------------------------------------------------------------------------
// One command is in flight at a time. After acceptance the unit sweeps the
// entry memory through its single read port in S_SCAN, waits out the read
// latency in S_DRAIN, updates the entry and the total in S_DECIDE, loads the
// output register in S_DONE (staying there while an earlier result still sits
// stalled in it), and takes the next command back in S_IDLE. The result then
// waits in the output register while the next command sweeps.
// Reset clears the occupancy flags at once, so no clearing pass is needed.
module multiset_count_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mct_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mct_pkg::t_out_word o_out_word
);
    import mct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [1:0]         r_cmd;
    logic [ELEM_W-1:0]  r_key;
    logic [IDX_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [TOTAL_W-1:0] r_total;
    t_out_word          r_res;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               in_acc;
    logic               rd_en;
    t_entry             rd_data;
    t_scan              scan;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [TOTAL_W-1:0] n_total;
    t_out_word          n_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign rd_en      = (r_state == S_SCAN);

    mct_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mct_scan u_scan (
        .i_clk   (i_clk),
        .i_clr   (in_acc),
        .i_en    (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_entry (rd_data),
        .i_key   (r_key),
        .o_scan  (scan)
    );

    // Update decision once the sweep is complete
    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = scan.found_idx;
        wr_data.value = r_key;
        wr_data.cnt   = scan.found_cnt;
        n_total       = r_total;
        n_res.status  = ST_OK;
        n_res.count   = '0;
        case (r_cmd)
            CMD_ADD: begin
                if (scan.found) begin
                    if (scan.found_cnt == '1) begin
                        n_res.status = ST_FULL;
                        n_res.count  = OUT_CNT_W'(scan.found_cnt);
                    end else begin
                        wr_en       = (r_state == S_DECIDE);
                        wr_data.cnt = scan.found_cnt + CNT_W'(1);
                        n_total     = r_total + TOTAL_W'(1);
                        n_res.count = OUT_CNT_W'(wr_data.cnt);
                    end
                end else if (scan.free_found) begin
                    wr_en       = (r_state == S_DECIDE);
                    wr_addr     = scan.free_idx;
                    wr_data.cnt = CNT_W'(1);
                    n_total     = r_total + TOTAL_W'(1);
                    n_res.count = OUT_CNT_W'(1);
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (scan.found) begin
                    wr_en       = (r_state == S_DECIDE);
                    wr_data.cnt = scan.found_cnt - CNT_W'(1);
                    n_total     = r_total - TOTAL_W'(1);
                    n_res.count = OUT_CNT_W'(wr_data.cnt);
                end else begin
                    n_res.status = ST_NOTFOUND;
                end
            end
            CMD_COUNT: begin
                if (scan.found) begin
                    n_res.count = OUT_CNT_W'(scan.found_cnt);
                end
            end
            default: begin
                n_res.count = OUT_CNT_W'(scan.nbest);
            end
        endcase
        n_res.total_elements = n_total;
        n_res.is_empty       = (n_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            r_rd_idx <= r_addr;
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_in_word.cmd;
                        r_key   <= ELEM_W'(i_in_word.elem_value);
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == IDX_W'(ENTRIES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_total <= n_total;
                    r_res   <= n_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_word  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/core/mct_chk.sv @@
// ----------------------------------------------------------------------------
// mct_chk
// Port-level checks for the multiset count table unit.
// ----------------------------------------------------------------------------
module mct_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mct_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mct_pkg::t_out_word o_out_word
);
    import mct_pkg::*;

    // One command at a time: stall right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.is_empty == (o_out_word.total_elements == '0))
                         && (o_out_word.status != 2'd3)))
        else $error("inconsistent result word");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_NOTFOUND) |-> (o_out_word.count == '0))
        else $error("not-found result with nonzero count");

endmodule

bind multiset_count_table_unit mct_chk u_mct_chk (.*);
